### hdl/life_automaton_torus_assert.svh
// assertion macros shared by the life grid rtl
`ifndef LIFE_AUTOMATON_TORUS_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("life grid check failed");

// next-cycle implication, checked on every rising edge outside reset
`define LAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("life grid check failed");

`endif

### hdl/lat_pkg.sv
package lat_pkg;

  // field widths of the command and result transfers
  localparam int CMD_W   = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int CFG_W   = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // size register value after reset
  localparam int CFG_RESET_VALUE = 64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // register indexes on the configuration channel
  localparam logic [0:0] REG_ROWS    = 1'b0;
  localparam logic [0:0] REG_COLUMNS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIXUP,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  // control of one row cell in the ring
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### hdl/lat_row_cell.sv
module lat_row_cell #(
  parameter int WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lat_pkg::cell_ctrl_t   ctrl_i,
  input  logic [WIDTH-1:0]      data_i,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] row_q;

  // one grid row, cleared at once or loaded from its neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.clear) begin
      row_q <= '0;
    end else if (ctrl_i.shift) begin
      row_q <= data_i;
    end
  end

  assign data_o = row_q;

endmodule

### hdl/lat_row_rule.sv
module lat_row_rule #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]             up_i,
  input  logic [COLS-1:0]             cur_i,
  input  logic [COLS-1:0]             down_i,
  input  logic [$clog2(COLS+1)-1:0]   ncols_i,
  output logic [COLS-1:0]             next_o
);

  localparam int IW  = $clog2(COLS);
  localparam int CCW = $clog2(COLS+1);

  logic [IW-1:0] last_idx;
  logic          up_last;
  logic          cur_last;
  logic          down_last;

  // bits of the last column in use, left neighbors of column zero
  assign last_idx  = IW'(ncols_i - CCW'(1));
  assign up_last   = up_i[last_idx];
  assign cur_last  = cur_i[last_idx];
  assign down_last = down_i[last_idx];

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic       ul, ur, cl, cr, dl, dr;
    logic       wrap_right;
    logic [3:0] cnt;
    logic       live;

    // left neighbors, wrapping to the last column in use
    if (c == 0) begin : g_left_wrap
      assign ul = up_last;
      assign cl = cur_last;
      assign dl = down_last;
    end else begin : g_left
      assign ul = up_i[c-1];
      assign cl = cur_i[c-1];
      assign dl = down_i[c-1];
    end

    // right neighbors, wrapping to column zero at the last column in use
    assign wrap_right = (CCW'(c + 1) == ncols_i);
    if (c == COLS-1) begin : g_right_wrap
      assign ur = up_i[0];
      assign cr = cur_i[0];
      assign dr = down_i[0];
    end else begin : g_right
      assign ur = wrap_right ? up_i[0]   : up_i[c+1];
      assign cr = wrap_right ? cur_i[0]  : cur_i[c+1];
      assign dr = wrap_right ? down_i[0] : down_i[c+1];
    end

    assign cnt = 4'(ul) + 4'(up_i[c]) + 4'(ur) + 4'(cl) + 4'(cr)
               + 4'(dl) + 4'(down_i[c]) + 4'(dr);

    // birth on three, survival on two or three
    assign live = (cnt == lat_pkg::BIRTH_COUNT)
               || (cur_i[c] && (cnt == lat_pkg::SURVIVE_COUNT));

    assign next_o[c] = live && (CCW'(c) < ncols_i);
  end

endmodule

### hdl/life_automaton_torus.sv
// channel   | direction | transfer
// s_axis    | in        | one command: tdata = command, cell_row, cell_column, new_value
// m_axis    | out       | one result per command: tdata = cell_state, command_done
// cfg       | in        | size register write: index 0 rows in use, 1 columns in use
//
// set, read, advance: the row ring turns once, one row word per cycle past the
// shared row rule at its head; advance then rewrites row zero from saved copies;
// clear empties every row at once.
// reset clears the grid and sets both sizes to 64 (clamped to the maximum).
// a waiting result holds the finish step; a new command is taken while it waits.
module life_automaton_torus #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command, bits from low: command[1:0], cell_row[7:2], cell_column[13:8],
  // new_value[14], zero pad[15]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // result, bits from low: cell_state[0], command_done[2:1], zero pad[7:3]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // size register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [0:0]                       cfg_index_i,
  input  logic [lat_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS+1);
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CCW = $clog2(MAX_COLUMNS+1);
  localparam int RESET_ROWS =
    (lat_pkg::CFG_RESET_VALUE > MAX_ROWS) ? MAX_ROWS : lat_pkg::CFG_RESET_VALUE;
  localparam int RESET_COLS =
    (lat_pkg::CFG_RESET_VALUE > MAX_COLUMNS) ? MAX_COLUMNS : lat_pkg::CFG_RESET_VALUE;

  lat_pkg::state_e state_q, state_d;

  logic [RCW-1:0] nrows_q, nrows_d, rows_clamp;
  logic [CCW-1:0] ncols_q, ncols_d, cols_clamp;

  lat_pkg::cmd_e              cmd_q;
  logic [lat_pkg::ROW_W-1:0]  row_q;
  logic [lat_pkg::COL_W-1:0]  col_q;
  logic                       val_q;
  logic [RW-1:0]              step_q, step_d;
  logic                       rd_q;

  logic [MAX_COLUMNS-1:0] prev_q, row0_q, row1_q, last_q;
  logic [MAX_COLUMNS-1:0] row_w [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] head, tail_d, set_row, bit_mask;
  logic [MAX_COLUMNS-1:0] rule_up, rule_down, rule_row;

  logic in_xfer, out_free, load_out;
  logic step_last, at_row, at_first, at_second, at_nr_last, in_use_row, in_grid;
  logic [CW-1:0] col_idx;

  logic                   m_valid_q, m_valid_d;
  logic [lat_pkg::OUT_TDATA_W-1:0] m_data_q;

  lat_pkg::cell_ctrl_t ring_ctrl, head_ctrl;

  // ---------------------------------------------------------------
  // size registers, clamped to 1..max on write
  always_comb begin
    if (cfg_data_i == '0) begin
      rows_clamp = RCW'(1);
    end else if (int'(cfg_data_i) > MAX_ROWS) begin
      rows_clamp = RCW'(MAX_ROWS);
    end else begin
      rows_clamp = RCW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      cols_clamp = CCW'(1);
    end else if (int'(cfg_data_i) > MAX_COLUMNS) begin
      cols_clamp = CCW'(MAX_COLUMNS);
    end else begin
      cols_clamp = CCW'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    nrows_d = nrows_q;
    ncols_d = ncols_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lat_pkg::REG_ROWS:    nrows_d = rows_clamp;
        lat_pkg::REG_COLUMNS: ncols_d = cols_clamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrows_q <= RCW'(RESET_ROWS);
      ncols_q <= CCW'(RESET_COLS);
    end else begin
      nrows_q <= nrows_d;
      ncols_q <= ncols_d;
    end
  end

  // ---------------------------------------------------------------
  // sweep position decode
  assign head       = row_w[0];
  assign step_last  = (step_q == RW'(MAX_ROWS-1));
  assign at_row     = (int'(step_q) == int'(row_q));
  assign at_first   = (step_q == '0);
  assign at_second  = (step_q == RW'(1));
  assign at_nr_last = (int'(step_q) == int'(nrows_q) - 1);
  assign in_use_row = (int'(step_q) < int'(nrows_q));
  assign in_grid    = (int'(row_q) < int'(nrows_q)) && (int'(col_q) < int'(ncols_q));
  assign col_idx    = col_q[CW-1:0];

  // ---------------------------------------------------------------
  // shared row rule: row zero is done last, from saved copies
  always_comb begin
    if (state_q == lat_pkg::ST_FIXUP) begin
      rule_up   = last_q;
      rule_down = (nrows_q == RCW'(1)) ? row0_q : row1_q;
    end else begin
      rule_up   = prev_q;
      rule_down = at_nr_last ? row0_q : row_w[1];
    end
  end

  lat_row_rule #(
    .COLS (MAX_COLUMNS)
  ) u_rule (
    .up_i    (rule_up),
    .cur_i   (head),
    .down_i  (rule_down),
    .ncols_i (ncols_q),
    .next_o  (rule_row)
  );

  // row written back into the tail of the ring
  assign bit_mask = {{(MAX_COLUMNS-1){1'b0}}, 1'b1} << col_idx;
  assign set_row  = val_q ? (head | bit_mask) : (head & ~bit_mask);

  always_comb begin
    case (cmd_q)
      lat_pkg::CMD_SET:     tail_d = (at_row && in_grid) ? set_row : head;
      lat_pkg::CMD_READ:    tail_d = head;
      lat_pkg::CMD_ADVANCE: tail_d = at_first ? head : (in_use_row ? rule_row : '0);
      default:              tail_d = head;
    endcase
  end

  // ---------------------------------------------------------------
  // ring of row cells, row word moves one place toward the head per cycle during a sweep
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_ring
    if (i == 0) begin : g_head
      lat_row_cell #(
        .WIDTH (MAX_COLUMNS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (head_ctrl),
        .data_i ((state_q == lat_pkg::ST_FIXUP) ? rule_row : row_w[1]),
        .data_o (row_w[0])
      );
    end else if (i == MAX_ROWS-1) begin : g_tail
      lat_row_cell #(
        .WIDTH (MAX_COLUMNS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ring_ctrl),
        .data_i (tail_d),
        .data_o (row_w[i])
      );
    end else begin : g_mid
      lat_row_cell #(
        .WIDTH (MAX_COLUMNS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ring_ctrl),
        .data_i (row_w[i+1]),
        .data_o (row_w[i])
      );
    end
  end

  // ---------------------------------------------------------------
  // sequencer next state
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lat_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (lat_pkg::cmd_e'(s_axis_tdata[1:0]) == lat_pkg::CMD_CLEAR) ?
                    lat_pkg::ST_CLEAR : lat_pkg::ST_SWEEP;
        end
      end
      lat_pkg::ST_SWEEP: begin
        if (step_last) begin
          state_d = (cmd_q == lat_pkg::CMD_ADVANCE) ? lat_pkg::ST_FIXUP : lat_pkg::ST_FINISH;
        end
      end
      lat_pkg::ST_FIXUP:  state_d = lat_pkg::ST_FINISH;
      lat_pkg::ST_CLEAR:  state_d = lat_pkg::ST_FINISH;
      lat_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = lat_pkg::ST_IDLE;
        end
      end
      default: state_d = lat_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    load_out        = 1'b0;
    ring_ctrl       = '0;
    head_ctrl       = '0;
    step_d          = step_q;
    case (state_q)
      lat_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        step_d        = '0;
      end
      lat_pkg::ST_SWEEP: begin
        ring_ctrl.shift = 1'b1;
        head_ctrl.shift = 1'b1;
        step_d          = step_last ? '0 : step_q + RW'(1);
      end
      lat_pkg::ST_FIXUP: begin
        head_ctrl.shift = 1'b1;
      end
      lat_pkg::ST_CLEAR: begin
        ring_ctrl.clear = 1'b1;
        head_ctrl.clear = 1'b1;
      end
      lat_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lat_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // ---------------------------------------------------------------
  // command fields, captured on the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= lat_pkg::CMD_SET;
    end else if (in_xfer) begin
      cmd_q <= lat_pkg::cmd_e'(s_axis_tdata[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      row_q <= s_axis_tdata[7:2];
      col_q <= s_axis_tdata[13:8];
      val_q <= s_axis_tdata[14];
    end
  end

  // saved original rows for the wrap rows of a generation
  always_ff @(posedge clk_i) begin
    if (state_q == lat_pkg::ST_SWEEP) begin
      prev_q <= head;
      if (at_first) begin
        row0_q <= head;
      end
      if (at_second) begin
        row1_q <= head;
      end
      if (at_nr_last) begin
        last_q <= head;
      end
    end
  end

  // read result bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
    end else if (in_xfer) begin
      rd_q <= 1'b0;
    end else if ((state_q == lat_pkg::ST_SWEEP) && (cmd_q == lat_pkg::CMD_READ)
                 && at_row && in_grid) begin
      rd_q <= head[col_idx];
    end
  end

  // ---------------------------------------------------------------
  // result register
  always_comb begin
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {5'b0, cmd_q, (cmd_q == lat_pkg::CMD_READ) ? rd_q : 1'b0};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------
  // checks
`include "life_automaton_torus_assert.svh"

  `LAT_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LAT_ASSERT_NEXT(a_result_from_finish, (state_q == lat_pkg::ST_FINISH) && out_free, m_axis_tvalid)
  `LAT_ASSERT_NEXT(a_sweep_ends, (state_q == lat_pkg::ST_SWEEP) && step_last, state_q != lat_pkg::ST_SWEEP)
  `LAT_ASSERT_NOW(a_fixup_on_advance, state_q == lat_pkg::ST_FIXUP, cmd_q == lat_pkg::CMD_ADVANCE)

endmodule

### tb/tb_life_automaton_torus.sv
`timescale 1ns / 100ps

module tb_life_automaton_torus;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = GRID_ROWS + 8;

  // one result transfer as the block should send it
  typedef struct packed {
    logic          cell_state;
    lat_pkg::cmd_e command_done;
  } result_t;

  // grid predictor and queue of results still owed by the block
  class grid_tracker;
    logic [GRID_COLS-1:0]      grid [GRID_ROWS];
    logic [lat_pkg::CFG_W-1:0] rows_reg;
    logic [lat_pkg::CFG_W-1:0] cols_reg;
    result_t                   pending_results[$];
    int                        mismatches;
    int                        live_reads;

    function new();
      foreach (grid[r]) grid[r] = '0;
      rows_reg   = lat_pkg::CFG_W'(lat_pkg::CFG_RESET_VALUE);
      cols_reg   = lat_pkg::CFG_W'(lat_pkg::CFG_RESET_VALUE);
      mismatches = 0;
      live_reads = 0;
    endfunction

    // size registers clamp to 1..max
    function int active_rows();
      int n;
      n = int'(rows_reg);
      if (n < 1) n = 1;
      if (n > GRID_ROWS) n = GRID_ROWS;
      return n;
    endfunction

    function int active_cols();
      int n;
      n = int'(cols_reg);
      if (n < 1) n = 1;
      if (n > GRID_COLS) n = GRID_COLS;
      return n;
    endfunction

    function void set_size(logic [0:0] index, logic [lat_pkg::CFG_W-1:0] value);
      if (index == lat_pkg::REG_ROWS) rows_reg = value;
      else cols_reg = value;
    endfunction

    // eight neighbors with wrap; on a tiny torus a cell may count several times
    function int neighbor_count(int r, int c, int nr, int nc);
      int total;
      int rr;
      int cc;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0) begin
            rr = (r + dr + nr) % nr;
            cc = (c + dc + nc) % nc;
            total += int'(grid[rr][cc]);
          end
        end
      end
      return total;
    endfunction

    // whole grid updates at once, cells outside the size in use die
    function void advance_generation();
      logic [GRID_COLS-1:0] next_grid [GRID_ROWS];
      int nr;
      int nc;
      int n;
      nr = active_rows();
      nc = active_cols();
      foreach (next_grid[r]) next_grid[r] = '0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = neighbor_count(r, c, nr, nc);
          if (grid[r][c]) begin
            next_grid[r][c] = (n == lat_pkg::SURVIVE_COUNT) || (n == lat_pkg::BIRTH_COUNT);
          end else begin
            next_grid[r][c] = (n == lat_pkg::BIRTH_COUNT);
          end
        end
      end
      grid = next_grid;
    endfunction

    function void note_command(lat_pkg::cmd_e cmd, int row, int col, logic value);
      result_t expected;
      logic    in_use;
      expected.cell_state   = 1'b0;
      expected.command_done = cmd;
      in_use = (row < active_rows()) && (col < active_cols());
      case (cmd)
        lat_pkg::CMD_SET: begin
          if (in_use) grid[row][col] = value;
        end
        lat_pkg::CMD_READ: begin
          if (in_use) expected.cell_state = grid[row][col];
        end
        lat_pkg::CMD_ADVANCE: advance_generation();
        lat_pkg::CMD_CLEAR: begin
          foreach (grid[r]) grid[r] = '0;
        end
        default: ;
      endcase
      pending_results.push_back(expected);
    endfunction

    task report(string what);
      mismatches++;
      $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [lat_pkg::OUT_TDATA_W-1:0] word);
      result_t expected;
      if (pending_results.size() == 0) begin
        report($sformatf("result 0x%02h with no command outstanding", word));
      end else begin
        expected = pending_results.pop_front();
        if (word[2:1] !== expected.command_done)
          report($sformatf("command_done %0d, expected %s", word[2:1],
                           expected.command_done.name()));
        if (word[0] !== expected.cell_state)
          report($sformatf("cell_state %b for %s, expected %b", word[0],
                           expected.command_done.name(), expected.cell_state));
        if (expected.command_done == lat_pkg::CMD_READ && expected.cell_state) live_reads++;
      end
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lat_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lat_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [0:0]                      cfg_index_i   = '0;
  logic [lat_pkg::CFG_W-1:0]       cfg_data_i    = '0;

  grid_tracker sb = new();

  int cycle_count = 0;
  int items_sent  = 0;
  int size_writes = 0;
  int command_count [4];
  int anchor_row  = 0;
  int anchor_col  = 0;
  bit steady      = 1'b0;
  bit hold_request = 1'b0;
  bit hold_off    = 1'b0;

  life_automaton_torus uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  // receiver readiness
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (steady) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 99) >= 27);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_off     <= 1'b1;
        hold_request <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // one command transfer, with random idle cycles ahead of it unless steady
  task automatic issue(lat_pkg::cmd_e cmd, int row, int col, bit value);
    if (!steady) begin
      while ($urandom_range(0, 99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value, 6'(col), 6'(row), cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, row, col, value);
    command_count[cmd]++;
    items_sent++;
  endtask

  // size register write once every result is back
  task automatic write_size(logic [0:0] index, int value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= lat_pkg::CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_size(index, lat_pkg::CFG_W'(value));
    size_writes++;
    @(posedge clk_i);
  endtask

  // cell near the current anchor, now and then anywhere in the field range
  function automatic void pick_cell(output int row, output int col, input int spread);
    int nr;
    int nc;
    nr = sb.active_rows();
    nc = sb.active_cols();
    if ($urandom_range(0, 9) == 0) begin
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
    end else begin
      row = (anchor_row + $urandom_range(0, spread) + nr - 1) % nr;
      col = (anchor_col + $urandom_range(0, spread) + nc - 1) % nc;
    end
  endfunction

  // seed a pattern, run a few generations and read around it, plus noise
  task automatic run_phase(int rows_val, int cols_val, int budget, bit with_hold);
    int first;
    int row;
    int col;
    bit held;
    held = 1'b0;
    write_size(lat_pkg::REG_ROWS, rows_val);
    write_size(lat_pkg::REG_COLUMNS, cols_val);
    first = items_sent;
    while (items_sent - first < budget) begin
      if (with_hold && !held && (items_sent - first > budget / 2)) begin
        hold_request <= 1'b1;
        held = 1'b1;
      end
      anchor_row = $urandom_range(0, sb.active_rows() - 1);
      anchor_col = $urandom_range(0, sb.active_cols() - 1);
      if ($urandom_range(0, 3) == 0)
        issue(lat_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
              1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 12)) begin
        pick_cell(row, col, 4);
        issue(lat_pkg::CMD_SET, row, col, $urandom_range(0, 5) != 0);
      end
      repeat ($urandom_range(1, 6)) begin
        issue(lat_pkg::CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
              1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) begin
          pick_cell(row, col, 6);
          issue(lat_pkg::CMD_READ, row, col, 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 3) == 0)
        issue(lat_pkg::cmd_e'($urandom_range(0, 3)), $urandom_range(0, 63),
              $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    foreach (command_count[i]) command_count[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the full grid at reset size
    issue(lat_pkg::CMD_SET, 0, 0, 1'b1);
    issue(lat_pkg::CMD_SET, 63, 63, 1'b1);
    issue(lat_pkg::CMD_SET, 0, 63, 1'b1);
    issue(lat_pkg::CMD_SET, 63, 0, 1'b1);
    issue(lat_pkg::CMD_READ, 63, 63, 1'b0);
    issue(lat_pkg::CMD_READ, 63, 0, 1'b1);
    issue(lat_pkg::CMD_SET, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 0, 63, 1'b0);
    // corner cells are neighbors across both wraps
    issue(lat_pkg::CMD_ADVANCE, 63, 63, 1'b1);
    issue(lat_pkg::CMD_READ, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 63, 63, 1'b0);
    issue(lat_pkg::CMD_CLEAR, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 63, 63, 1'b0);
    // blinker straddling the column wrap
    issue(lat_pkg::CMD_SET, 0, 62, 1'b1);
    issue(lat_pkg::CMD_SET, 0, 63, 1'b1);
    issue(lat_pkg::CMD_SET, 0, 0, 1'b1);
    issue(lat_pkg::CMD_ADVANCE, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 63, 63, 1'b0);
    issue(lat_pkg::CMD_READ, 1, 63, 1'b0);
    issue(lat_pkg::CMD_READ, 0, 62, 1'b0);
    issue(lat_pkg::CMD_ADVANCE, 0, 0, 1'b0);
    issue(lat_pkg::CMD_READ, 0, 62, 1'b0);
    issue(lat_pkg::CMD_READ, 0, 0, 1'b0);

    // size settings: reset size, tiny tori, clamped values, odd shapes
    run_phase(64, 64, 150, 1'b1);
    run_phase(1, 1, 60, 1'b0);
    run_phase(2, 2, 80, 1'b0);
    run_phase(0, 127, 80, 1'b0);
    run_phase(3, 3, 90, 1'b0);
    run_phase(127, 0, 60, 1'b0);
    steady = 1'b1;
    run_phase(5, 7, 100, 1'b0);
    steady = 1'b0;
    run_phase(2, 64, 70, 1'b0);
    run_phase(64, 2, 70, 1'b0);
    repeat (3) run_phase($urandom_range(0, 127), $urandom_range(0, 127), 80, 1'b0);

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d commands: %0d set, %0d read (%0d live), %0d advance, %0d clear",
             items_sent, command_count[lat_pkg::CMD_SET], command_count[lat_pkg::CMD_READ],
             sb.live_reads, command_count[lat_pkg::CMD_ADVANCE],
             command_count[lat_pkg::CMD_CLEAR]);
    $display("tb: %0d size register writes incl. tiny and clamped sizes, %0d mismatches",
             size_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
